/* rtl/nffr_pkg.sv */
`timescale 1ns / 1ps

package nffr_pkg;

  // term counts of the rational fit
  localparam int NUM_TERMS = 3;
  localparam int DEN_TERMS = 5;
  localparam int NCELLS = (NUM_TERMS > DEN_TERMS) ? NUM_TERMS : DEN_TERMS;
  localparam int IW = $clog2(NCELLS + 1);
  localparam int ROM_SLOTS = 8;

  // datapath widths
  localparam int TW = 24;                    // tau, Q4.20
  localparam int CW = 19;                    // coefficient, signed thousandths
  localparam int PW = 40 + 4 * NCELLS;       // tau^k with 40 fraction bits
  localparam int PH = (PW + 1) / 2;          // half of a power for split products
  localparam int SW = PW + CW + 3;           // signed polynomial sum
  localparam int MW = 31;                    // magnetic moment
  localparam int MC = (SW + 2) / 3;          // chunk of a sum for the moment product
  localparam int RW = SW + 32;               // dividend / shifted divisor
  localparam int QW = 32;                    // quotient bits and result width

  localparam logic signed [SW-1:0] SUM_ONE = SW'(1000) << 40;
  localparam logic [MW-1:0] MU_RESET = MW'(749699249);

  typedef enum logic [1:0] {
    KIND_AE,
    KIND_BE,
    KIND_AM,
    KIND_BM
  } coef_kind_t;

  // coefficient sets in thousandths: [fit_mode][term]
  localparam logic signed [CW-1:0] ROM_AE [4][ROM_SLOTS] = '{
    '{3439, -1602, 68, 0, 0, 0, 0, 0},
    '{4309, -1108, -324, 0, 0, 0, 0, 0},
    '{4286, -1281, -486, 0, 0, 0, 0, 0},
    '{4109, -1052, -375, 0, 0, 0, 0, 0}};
  localparam logic signed [CW-1:0] ROM_BE [4][ROM_SLOTS] = '{
    '{15055, 48061, 99304, 12, 8650, 0, 0, 0},
    '{15340, 58321, 124110, 3927, 589, 0, 0, 0},
    '{16308, 54535, 138030, 7005, 14, 0, 0, 0},
    '{15602, 55519, 123960, 11403, 1931, 0, 0, 0}};
  localparam logic signed [CW-1:0] ROM_AM [4][ROM_SLOTS] = '{
    '{-1465, 1260, 262, 0, 0, 0, 0, 0},
    '{-1472, 1210, 334, 0, 0, 0, 0, 0},
    '{-1374, 1080, 124, 0, 0, 0, 0, 0},
    '{-1436, 1196, 210, 0, 0, 0, 0, 0}};
  localparam logic signed [CW-1:0] ROM_BM [4][ROM_SLOTS] = '{
    '{9627, 0, 0, 11179, 13245, 0, 0, 0},
    '{9486, 0, 0, 9440, 15416, 0, 0, 0},
    '{10003, 0, 0, 7680, 9009, 0, 0, 0},
    '{9721, 0, 0, 9623, 11817, 0, 0, 0}};

  // one term cell's data, handed down the chain every cycle
  typedef struct packed {
    logic                 valid;
    logic [TW-1:0]        tau;
    logic [1:0]           mode;
    logic [PW-1:0]        p;
    logic signed [SW-1:0] ne;
    logic signed [SW-1:0] de;
    logic signed [SW-1:0] nm;
    logic signed [SW-1:0] dm;
  } term_bus_t;

  // one divider cell's data
  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          sat;
    logic [RW-1:0] rem;
    logic [RW-1:0] dsh;
    logic [QW-1:0] q;
  } div_bus_t;

  // coefficient lookup; terms past the count read as zero
  function automatic logic signed [CW-1:0] coef(input coef_kind_t kind,
                                                input logic [1:0] mode,
                                                input logic [IW-1:0] idx);
    logic signed [CW-1:0] c;
    c = '0;
    case (kind)
      KIND_AE: if (int'(idx) < NUM_TERMS) c = ROM_AE[mode][idx];
      KIND_BE: if (int'(idx) < DEN_TERMS) c = ROM_BE[mode][idx];
      KIND_AM: if (int'(idx) < NUM_TERMS) c = ROM_AM[mode][idx];
      KIND_BM: if (int'(idx) < DEN_TERMS) c = ROM_BM[mode][idx];
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/nffr_term_cell.sv */
`timescale 1ns / 1ps

// One polynomial term: adds coef*tau^k to all four sums and forms tau^(k+1).
// Two register stages: split products, then recombine and accumulate.
module nffr_term_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [nffr_pkg::IW-1:0]       idx,
  input  nffr_pkg::term_bus_t           bus_in,
  output nffr_pkg::term_bus_t           bus_out
);

  localparam int PH = nffr_pkg::PH;
  localparam int TW = nffr_pkg::TW;
  localparam int CW = nffr_pkg::CW;
  localparam int SW = nffr_pkg::SW;
  localparam int PW = nffr_pkg::PW;

  logic [PH-1:0] p_hi;
  logic [PH-1:0] p_lo;
  logic signed [CW-1:0] c [4];

  logic                  a_valid;
  logic [TW-1:0]         a_tau;
  logic [1:0]            a_mode;
  logic signed [SW-1:0]  a_ne, a_de, a_nm, a_dm;
  logic [PH+TW-1:0]      a_th, a_tl;
  logic signed [CW+PH:0] a_ph [4];
  logic signed [CW+PH:0] a_pl [4];

  logic [2*PH+TW-1:0]    prodt;
  logic signed [SW-1:0]  term [4];

  // operand split and coefficient fetch
  always_comb begin
    p_hi = PH'(bus_in.p >> PH);
    p_lo = bus_in.p[PH-1:0];
    c[0] = nffr_pkg::coef(nffr_pkg::KIND_AE, bus_in.mode, idx);
    c[1] = nffr_pkg::coef(nffr_pkg::KIND_BE, bus_in.mode, idx);
    c[2] = nffr_pkg::coef(nffr_pkg::KIND_AM, bus_in.mode, idx);
    c[3] = nffr_pkg::coef(nffr_pkg::KIND_BM, bus_in.mode, idx);
  end

  // stage A: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= bus_in.valid;
    end
    a_tau  <= bus_in.tau;
    a_mode <= bus_in.mode;
    a_ne   <= bus_in.ne;
    a_de   <= bus_in.de;
    a_nm   <= bus_in.nm;
    a_dm   <= bus_in.dm;
    a_th   <= p_hi * bus_in.tau;
    a_tl   <= p_lo * bus_in.tau;
    for (int k = 0; k < 4; k++) begin
      a_ph[k] <= c[k] * $signed({1'b0, p_hi});
      a_pl[k] <= c[k] * $signed({1'b0, p_lo});
    end
  end

  // recombine halves
  always_comb begin
    prodt = {a_th, {PH{1'b0}}} + (2*PH+TW)'(a_tl);
    for (int k = 0; k < 4; k++) begin
      term[k] = (SW'(a_ph[k]) <<< PH) + SW'(a_pl[k]);
    end
  end

  // stage B: next power and accumulated sums
  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out.valid <= a_valid;
    end
    bus_out.tau  <= a_tau;
    bus_out.mode <= a_mode;
    bus_out.p    <= prodt[PW+19:20];
    bus_out.ne   <= a_ne + term[0];
    bus_out.de   <= a_de + term[1];
    bus_out.nm   <= a_nm + term[2];
    bus_out.dm   <= a_dm + term[3];
  end

endmodule

/* rtl/nffr_div_cell.sv */
`timescale 1ns / 1ps

// One restoring-division step: one quotient bit, divisor shifts down by one.
module nffr_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  nffr_pkg::div_bus_t  bus_in,
  output nffr_pkg::div_bus_t  bus_out
);

  localparam int QW = nffr_pkg::QW;

  logic fits;

  assign fits = (bus_in.rem >= bus_in.dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_out.valid <= 1'b0;
    end else begin
      bus_out.valid <= bus_in.valid;
    end
    bus_out.neg <= bus_in.neg;
    bus_out.sat <= bus_in.sat;
    bus_out.rem <= fits ? (bus_in.rem - bus_in.dsh) : bus_in.rem;
    bus_out.dsh <= bus_in.dsh >> 1;
    bus_out.q   <= {bus_in.q[QW-2:0], fits};
  end

endmodule

/* rtl/nucleon_form_factor_rational_fit.sv */
`timescale 1ns / 1ps
// Pipeline: a request taken on start passes through the term cells, the
// sign/scale/setup stages, the divider cells and the output register before done pulses.
// Throughput: one request per cycle; every stage is a register in a fixed pipeline.
// Reset (rst, synchronous): flushes all in-flight requests, fit_mode to 0 and
// magnetic_moment to its default; busy is high only during reset. No output stall.
module nucleon_form_factor_rational_fit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [23:0]        tau,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] electric_ff,
  output logic signed [31:0] magnetic_ff
);

  localparam int NCELLS = nffr_pkg::NCELLS;
  localparam int IW = nffr_pkg::IW;
  localparam int SW = nffr_pkg::SW;
  localparam int PW = nffr_pkg::PW;
  localparam int MW = nffr_pkg::MW;
  localparam int MC = nffr_pkg::MC;
  localparam int RW = nffr_pkg::RW;
  localparam int QW = nffr_pkg::QW;

  localparam logic [1:0] REG_FIT_MODE = 2'd0;
  localparam logic [1:0] REG_MAGNETIC_MOMENT = 2'd1;

  logic [1:0]    fit_mode;
  logic [MW-1:0] magnetic_moment;

  // config registers
  assign cfg_ready = ~rst;
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode        <= 2'd0;
      magnetic_moment <= nffr_pkg::MU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIT_MODE:        fit_mode <= cfg_data[1:0];
        REG_MAGNETIC_MOMENT: magnetic_moment <= cfg_data[MW-1:0];
        default:             ;
      endcase
    end
  end

  assign busy = rst;

  // term cell chain
  nffr_pkg::term_bus_t tb [NCELLS+1];

  always_comb begin
    tb[0].valid = start && !busy;
    tb[0].tau   = tau;
    tb[0].mode  = fit_mode;
    tb[0].p     = PW'({tau, 20'b0});
    tb[0].ne    = nffr_pkg::SUM_ONE;
    tb[0].de    = nffr_pkg::SUM_ONE;
    tb[0].nm    = nffr_pkg::SUM_ONE;
    tb[0].dm    = nffr_pkg::SUM_ONE;
  end

  for (genvar g = 0; g < NCELLS; g++) begin : g_term
    nffr_term_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .idx    (IW'(g)),
      .bus_in (tb[g]),
      .bus_out(tb[g+1])
    );
  end

  // S1: sign and magnitude
  logic          s1_valid, s1_neg_e, s1_neg_m;
  logic [SW-1:0] s1_mag_e, s1_mag_m, s1_de, s1_dm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= tb[NCELLS].valid;
    end
    s1_neg_e <= tb[NCELLS].ne[SW-1];
    s1_neg_m <= tb[NCELLS].nm[SW-1];
    s1_mag_e <= tb[NCELLS].ne[SW-1] ? SW'(-tb[NCELLS].ne) : SW'(tb[NCELLS].ne);
    s1_mag_m <= tb[NCELLS].nm[SW-1] ? SW'(-tb[NCELLS].nm) : SW'(tb[NCELLS].nm);
    s1_de    <= SW'(tb[NCELLS].de);
    s1_dm    <= SW'(tb[NCELLS].dm);
  end

  // S2: moment partial products
  logic [3*MC-1:0]    mag_m_ext;
  logic               s2_valid, s2_neg_e, s2_neg_m;
  logic [SW-1:0]      s2_mag_e, s2_de, s2_dm;
  logic [MC+MW-1:0]   s2_pm [3];

  assign mag_m_ext = (3*MC)'(s1_mag_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_neg_e <= s1_neg_e;
    s2_neg_m <= s1_neg_m;
    s2_mag_e <= s1_mag_e;
    s2_de    <= s1_de;
    s2_dm    <= s1_dm;
    for (int k = 0; k < 3; k++) begin
      s2_pm[k] <= mag_m_ext[k*MC +: MC] * magnetic_moment;
    end
  end

  // S3: scaled numerators
  logic          s3_valid, s3_neg_e, s3_neg_m;
  logic [RW-1:0] s3_n_e, s3_n_m;
  logic [SW-1:0] s3_de, s3_dm;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_neg_e <= s2_neg_e;
    s3_neg_m <= s2_neg_m;
    s3_n_e   <= RW'(s2_mag_e) << 28;
    s3_n_m   <= RW'(s2_pm[0]) + (RW'(s2_pm[1]) << MC) + (RW'(s2_pm[2]) << (2*MC));
    s3_de    <= s2_de;
    s3_dm    <= s2_dm;
  end

  // S4: overflow check and divider setup
  nffr_pkg::div_bus_t db_e [QW+1];
  nffr_pkg::div_bus_t db_m [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      db_e[0].valid <= 1'b0;
      db_m[0].valid <= 1'b0;
    end else begin
      db_e[0].valid <= s3_valid;
      db_m[0].valid <= s3_valid;
    end
    db_e[0].neg <= s3_neg_e;
    db_m[0].neg <= s3_neg_m;
    db_e[0].sat <= ((RW+1)'(s3_n_e) >= ((RW+1)'(s3_de) << QW));
    db_m[0].sat <= ((RW+1)'(s3_n_m) >= ((RW+1)'(s3_dm) << QW));
    db_e[0].rem <= s3_n_e;
    db_m[0].rem <= s3_n_m;
    db_e[0].dsh <= RW'(s3_de) << (QW-1);
    db_m[0].dsh <= RW'(s3_dm) << (QW-1);
    db_e[0].q   <= '0;
    db_m[0].q   <= '0;
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    nffr_div_cell u_div_e (
      .clk    (clk),
      .rst    (rst),
      .bus_in (db_e[g]),
      .bus_out(db_e[g+1])
    );
    nffr_div_cell u_div_m (
      .clk    (clk),
      .rst    (rst),
      .bus_in (db_m[g]),
      .bus_out(db_m[g+1])
    );
  end

  // sign and saturation to signed Q4.28
  function automatic logic [QW-1:0] sat_result(input logic neg, input logic sat,
                                               input logic [QW-1:0] q);
    logic [QW-1:0] r;
    if (neg) begin
      if (sat || q > {1'b1, {(QW-1){1'b0}}}) r = {1'b1, {(QW-1){1'b0}}};
      else r = -q;
    end else begin
      if (sat || q[QW-1]) r = {1'b0, {(QW-1){1'b1}}};
      else r = q;
    end
    return r;
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= db_e[QW].valid;
    end
    electric_ff <= sat_result(db_e[QW].neg, db_e[QW].sat, db_e[QW].q);
    magnetic_ff <= sat_result(db_m[QW].neg, db_m[QW].sat, db_m[QW].q);
  end

  // both divider chains move in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    db_e[QW/2].valid == db_m[QW/2].valid)
    else $error("divider chains out of step");

  // partial remainder stays below twice the current divisor
  a_div_rem_e: assert property (@(posedge clk) disable iff (rst)
    (db_e[QW/2].valid && !db_e[QW/2].sat) |->
      ({1'b0, db_e[QW/2].rem} < {db_e[QW/2].dsh, 1'b0}))
    else $error("electric remainder out of bound");

  a_div_rem_m: assert property (@(posedge clk) disable iff (rst)
    (db_m[QW/2].valid && !db_m[QW/2].sat) |->
      ({1'b0, db_m[QW/2].rem} < {db_m[QW/2].dsh, 1'b0}))
    else $error("magnetic remainder out of bound");

  // denominators never drop below one
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    tb[NCELLS].valid |->
      (tb[NCELLS].de >= nffr_pkg::SUM_ONE && tb[NCELLS].dm >= nffr_pkg::SUM_ONE))
    else $error("denominator below one");

endmodule
